FILE: hdl/sha256_hash_engine_assert.svh
// Assertion macros for the SHA-256 engine checker
`ifndef SHA256_HASH_ENGINE_ASSERT_SVH
`define SHA256_HASH_ENGINE_ASSERT_SVH
// Implication checked on every clock, disabled in reset
`define SHE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked on every clock, disabled in reset
`define SHE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: hdl/sha_pkg.sv
// Package: SHA-256 types, constants and round functions
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;
	localparam int BlockBytes = 64;
	localparam int Rounds     = 64;

	typedef enum logic [1:0] {
		CMD_APPEND        = 2'd0,
		CMD_APPEND_FINISH = 2'd1,
		CMD_FINISH        = 2'd2,
		CMD_NONE          = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] msg_byte;
	} in_item_t;

	localparam logic [31:0] InitH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction
	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction
	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction
	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction
endpackage
`default_nettype wire

FILE: hdl/sha_if.sv
// Valid/ready channel interface carrying one item
`timescale 1ns / 1ps
`default_nettype none
interface sha_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/sha256_hash_engine.sv
// Top level: SHA-256 engine with byte input and digest word output
// Each byte item is accepted while the engine is idle and written into a 64-byte block buffer.
// The buffer is held as 16 words, written one byte lane at a time and read one word per
// cycle. A full block is loaded (16 words, through a registered read), run through 64 rounds
// of one shared round unit and then added into the hash state. A finish feeds padding bytes
// through the same byte path (one per cycle, up to 72 bytes and two blocks), then presents
// the eight digest words H0..H7 one per accepted output item, and restarts the state for the
// next message. The input is not ready while a block is compressed, padding is inserted or
// the digest is sent.
`timescale 1ns / 1ps
`default_nettype none
module sha256_hash_engine import sha_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	sha_if.sink       in_ch,
	sha_if.source     out_ch
);
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LOAD  = 6'b000010,
		ST_ROUND = 6'b000100,
		ST_ADD   = 6'b001000,
		ST_PAD   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t      state_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [31:0] mem [BlockBytes / 4];
	logic [31:0] rd_q;
	logic [63:0] count_q;
	logic [5:0]  pos_q;     // padding write position
	logic [63:0] bits_q;    // length latched at finish
	logic        fin_q;     // padding in progress
	logic [1:0]  pphase_q;  // 0: 0x80, 1: zeros, 2: length
	logic [6:0]  step_q;
	logic [2:0]  oidx_q;

	in_item_t in_d;
	assign in_d = in_ch.data;

	// Byte writer: input or padding
	logic       wr_en;
	logic [5:0] wr_addr;
	logic [7:0] wr_data;
	logic [7:0] len_byte;
	assign len_byte = bits_q[63 - 8 * (pos_q[2:0]) -: 8];
	always_comb begin
		wr_en = 1'b0; wr_addr = count_q[5:0]; wr_data = in_d.msg_byte;
		if (state_q == ST_IDLE && in_ch.valid
			&& (in_d.cmd == CMD_APPEND || in_d.cmd == CMD_APPEND_FINISH))
			wr_en = 1'b1;
		if (state_q == ST_PAD) begin
			wr_en = 1'b1; wr_addr = pos_q;
			unique case (pphase_q)
				2'd0:    wr_data = 8'h80;
				2'd2:    wr_data = len_byte;
				default: wr_data = 8'h00;
			endcase
		end
	end

	// Block memory, written per byte lane, read per word
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr[5:2]][{~wr_addr[1:0], 3'd0} +: 8] <= wr_data;
		rd_q <= mem[step_q[3:0]];
	end

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.data  = '{digest_word: h_q[oidx_q], word_index: oidx_q,
		last_word: (oidx_q == 3'd7)};

	// Shared round unit
	logic [5:0]  rnd;
	logic [31:0] wt, wnew, t1, t2;
	assign rnd  = step_q[5:0];
	assign wnew = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
	assign wt   = (rnd < 6'd16) ? w_q[rnd[3:0]] : wnew;
	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ RoundK[rnd] + wt;
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; count_q <= '0; fin_q <= 1'b0; step_q <= '0;
			oidx_q <= '0; pos_q <= '0; pphase_q <= '0; bits_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
			for (int i = 0; i < 8; i++) v_q[i] <= '0;
			for (int i = 0; i < 16; i++) w_q[i] <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						priority if (in_d.cmd == CMD_APPEND) begin
							count_q <= count_q + 64'd1;
							if (count_q[5:0] == 6'd63) begin
								state_q <= ST_LOAD; step_q <= '0;
							end
						end else if (in_d.cmd == CMD_APPEND_FINISH) begin
							count_q <= count_q + 64'd1;
							bits_q <= {count_q[60:0] + 61'd1, 3'd0};
							pos_q <= count_q[5:0] + 6'd1;
							fin_q <= 1'b1; pphase_q <= 2'd0;
							if (count_q[5:0] == 6'd63) begin
								state_q <= ST_LOAD; step_q <= '0;
							end else state_q <= ST_PAD;
						end else if (in_d.cmd == CMD_FINISH) begin
							bits_q <= {count_q[60:0], 3'd0};
							pos_q <= count_q[5:0]; fin_q <= 1'b1; pphase_q <= 2'd0;
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_PAD: begin
					pos_q <= pos_q + 6'd1;
					// Switch to the length field after byte 55
					priority if (pos_q == 6'd55 && pphase_q != 2'd2) pphase_q <= 2'd2;
					else if (pphase_q == 2'd0) pphase_q <= 2'd1;
					else pphase_q <= pphase_q;
					if (pos_q == 6'd63) begin
						state_q <= ST_LOAD; step_q <= '0;
						if (pphase_q == 2'd2) fin_q <= 1'b0;
					end
				end
				ST_LOAD: begin
					// rd_q is a registered read: it holds the word addressed in the cycle before
					if (step_q != 7'd0) w_q[step_q[3:0] - 4'd1] <= rd_q;
					if (step_q == 7'd16) begin
						step_q <= '0; state_q <= ST_ROUND;
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				ST_ROUND: begin
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1; v_q[3] <= v_q[2]; v_q[2] <= v_q[1];
					v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
					if (rnd >= 6'd16) begin
						for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
						w_q[15] <= wnew;
					end
					step_q <= step_q + 7'd1;
					if (rnd == 6'(Rounds - 1)) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					// Digest is ready once the length block is folded in
					priority if (!fin_q && pphase_q == 2'd2) begin
						state_q <= ST_OUT; pphase_q <= 2'd0;
					end else if (!fin_q) state_q <= ST_IDLE;
					else state_q <= ST_PAD;
					oidx_q <= '0;
				end
				ST_OUT: begin
					if (out_ch.ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q <= ST_IDLE; count_q <= '0;
							for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: hdl/sha_chk.sv
// Port checker for the SHA-256 engine, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_hash_engine_assert.svh"
module sha_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  word_index,
	input wire logic        last_word
);
	`SHE_ASSERT_IMP(a_excl, clk, arst_n, out_valid, !in_ready)
	`SHE_ASSERT_IMP(a_last, clk, arst_n, out_valid, last_word == (word_index == 3'd7))
	`SHE_ASSERT_NEXT(a_adv, clk, arst_n, out_valid && out_ready && word_index != 3'd7,
		out_valid && word_index == $past(word_index) + 3'd1)
	`SHE_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(word_index))
endmodule
bind sha256_hash_engine sha_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.word_index(out_ch.data.word_index), .last_word(out_ch.data.last_word));
`default_nettype wire
